/* hw/rtl/fdp_pkg.sv */
// ----------------------------------------------------------------------------
// Frame deadline pacer package
// Widths, register indexes, rate mode codes and reset values shared by the
// pacer's interfaces and modules.
// ----------------------------------------------------------------------------
package fdp_pkg;

  localparam int FREQ_W  = 32;                 // counter frequency and period
  localparam int RATE_W  = 10;                 // frames per second
  localparam int LEAD_W  = 10;                 // lead in milliseconds
  localparam int TIME_W  = 63;                 // counter time
  localparam int ACC_W   = 64;                 // schedule arithmetic
  localparam int FC_W    = 32;                 // frame count
  localparam int MODE_W  = 2;
  localparam int IDX_W   = 3;
  localparam int MS_PER_S = 1000;
  localparam int KQ_W    = 23;                 // holds (2^32-1)/1000
  localparam int LCAP_W  = KQ_W + LEAD_W;
  localparam int DSTEP_W = $clog2(FREQ_W);
  localparam int MSTEP_W = $clog2(FC_W);

  typedef logic [FREQ_W-1:0] freq_t;
  typedef logic [RATE_W-1:0] rate_t;
  typedef logic [TIME_W-1:0] time_t;
  typedef logic [ACC_W-1:0]  acc_t;
  typedef logic [FC_W-1:0]   fcount_t;
  typedef logic [MODE_W-1:0] mode_t;
  typedef logic [IDX_W-1:0]  reg_idx_t;

  // Rate mode codes; the unused code behaves as normal.
  localparam mode_t MODE_NORMAL = 2'd0;
  localparam mode_t MODE_FAST   = 2'd1;
  localparam mode_t MODE_SLOW   = 2'd2;

  // Configuration register indexes.
  localparam reg_idx_t REG_COUNTER_FREQ = 3'd0;
  localparam reg_idx_t REG_NORMAL_RATE  = 3'd1;
  localparam reg_idx_t REG_FAST_RATE    = 3'd2;
  localparam reg_idx_t REG_SLOW_RATE    = 3'd3;
  localparam reg_idx_t REG_LEAD_MS      = 3'd4;
  localparam reg_idx_t REG_SPEED_EN     = 3'd5;

  // Reset values of the configuration registers.
  localparam freq_t RST_COUNTER_FREQ = 32'd10000000;
  localparam rate_t RST_NORMAL_RATE  = 10'd60;
  localparam rate_t RST_FAST_RATE    = 10'd240;
  localparam rate_t RST_SLOW_RATE    = 10'd30;
  localparam logic [LEAD_W-1:0] RST_LEAD_MS = 10'd0;

endpackage

/* hw/rtl/fdp_if.sv */
// ----------------------------------------------------------------------------
// Frame deadline pacer channels
// Valid/ready channels for frame ticks and for the deadline results.
// ----------------------------------------------------------------------------
interface fdp_in_if;
  import fdp_pkg::*;

  logic  valid;
  logic  ready;
  time_t now;
  mode_t rate_mode;

  modport source (output valid, output now, output rate_mode, input ready);
  modport sink   (input valid, input now, input rate_mode, output ready);
endinterface

interface fdp_out_if;
  import fdp_pkg::*;

  logic  valid;
  logic  ready;
  time_t deadline;
  logic  resynced;
  logic  temporary_rate;

  modport source (output valid, output deadline, output resynced,
                  output temporary_rate, input ready);
  modport sink   (input valid, input deadline, input resynced,
                  input temporary_rate, output ready);
endinterface

/* hw/rtl/frame_deadline_pacer_unit.sv */
// ----------------------------------------------------------------------------
// Frame deadline pacer
// Turns frame ticks into paced deadlines: picks the rate, derives period and
// early-release lead, and keeps or restarts the frame schedule.
//
//   Channel | Direction | Handshake    | Payload
//   in_ch   | in        | valid/ready  | now, rate_mode
//   out_ch  | out       | valid/ready  | deadline, resynced, temporary_rate
//   cfg_*   | in        | write enable | cfg_idx, cfg_wdata
//
// A tick is accepted only while the unit is idle, so a new tick waits until the
// last one is done: two bit-serial dividers run side by side for 32 steps
// (period and freq/1000), then a bit-serial multiply-accumulate takes 32 steps
// for start+count*period, then ST_ADJ applies the lead and ST_CMP compares.
// Reset is synchronous and active low. The result sits in an output register;
// a stalled result holds the compare state until the register frees up.
// ----------------------------------------------------------------------------
module frame_deadline_pacer_unit (
  input  logic              clk,
  input  logic              rst_n,
  fdp_in_if.sink            in_ch,
  fdp_out_if.source         out_ch,
  input  logic              cfg_we,
  input  fdp_pkg::reg_idx_t cfg_idx,
  input  fdp_pkg::freq_t    cfg_wdata
);
  import fdp_pkg::*;

  typedef enum logic [2:0] {ST_IDLE, ST_DIV, ST_MUL, ST_ADJ, ST_CMP} state_t;

  // Configuration.
  freq_t              freq_r;
  rate_t              normal_r;
  rate_t              fast_r;
  rate_t              slow_r;
  logic [LEAD_W-1:0]  lead_ms_r;
  logic               spd_en_r;

  // Schedule state.
  acc_t    sched_start_r;
  fcount_t frame_count_r;
  freq_t   last_period_r;

  // Per-tick working registers.
  state_t         state_r;
  time_t          now_r;
  logic           temp_r;
  freq_t          period_r;
  logic [KQ_W-1:0] kq_r;
  freq_t          lead_r;
  acc_t           target_r;

  // Result register.
  logic  out_valid_r;
  time_t out_deadline_r;
  logic  out_resynced_r;
  logic  out_temp_r;

  logic  in_xfer;
  rate_t sel_rate;
  rate_t div_rate;
  freq_t per_q;
  freq_t kq_q;
  logic  per_done;
  logic  kq_done;
  logic  mul_start;
  acc_t  mul_p;
  logic  mul_done;
  fcount_t count_inc;

  logic [LCAP_W-1:0] lead_cap;
  freq_t             half_period;
  freq_t             lead_nxt;
  acc_t              target_adj;
  acc_t              slot_end;
  logic              keep;
  logic              out_free;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    sel_rate = normal_r;
    if (spd_en_r) begin
      if (in_ch.rate_mode == MODE_FAST) begin
        sel_rate = fast_r;
      end else if (in_ch.rate_mode == MODE_SLOW) begin
        sel_rate = slow_r;
      end
    end
    // A zero rate divides as one.
    div_rate = (sel_rate == '0) ? RATE_W'(1) : sel_rate;
  end

  assign count_inc = frame_count_r + FC_W'(1);
  assign mul_start = (state_r == ST_DIV) && per_done;

  fdp_sdiv u_per_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .dividend (freq_r),
    .divisor  (div_rate),
    .quotient (per_q),
    .done     (per_done)
  );

  fdp_sdiv u_ms_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_xfer),
    .dividend (freq_r),
    .divisor  (RATE_W'(MS_PER_S)),
    .quotient (kq_q),
    .done     (kq_done)
  );

  fdp_smul u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .addend  (sched_start_r),
    .mcand   (per_q),
    .mplier  (count_inc),
    .product (mul_p),
    .done    (mul_done)
  );

  always_comb begin
    lead_cap    = LCAP_W'(kq_r) * LCAP_W'(lead_ms_r);
    half_period = {1'b0, period_r[FREQ_W-1:1]};
    lead_nxt    = (lead_cap < LCAP_W'(half_period)) ? lead_cap[FREQ_W-1:0] : half_period;
    // The lead only applies while the normal rate is in use.
    target_adj  = temp_r ? target_r : (target_r - ACC_W'(lead_r));
    slot_end    = target_r + ACC_W'(period_r);
    keep        = (slot_end >= ACC_W'(now_r)) && (period_r == last_period_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_r        <= RST_COUNTER_FREQ;
      normal_r      <= RST_NORMAL_RATE;
      fast_r        <= RST_FAST_RATE;
      slow_r        <= RST_SLOW_RATE;
      lead_ms_r     <= RST_LEAD_MS;
      spd_en_r      <= 1'b0;
      sched_start_r <= '0;
      frame_count_r <= '0;
      last_period_r <= '0;
      state_r       <= ST_IDLE;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_COUNTER_FREQ: freq_r <= cfg_wdata;
          REG_NORMAL_RATE: begin
            // A zero normal rate is rejected.
            if (cfg_wdata[RATE_W-1:0] != '0) begin
              normal_r <= cfg_wdata[RATE_W-1:0];
            end
          end
          REG_FAST_RATE:    fast_r    <= cfg_wdata[RATE_W-1:0];
          REG_SLOW_RATE:    slow_r    <= cfg_wdata[RATE_W-1:0];
          REG_LEAD_MS:      lead_ms_r <= cfg_wdata[LEAD_W-1:0];
          REG_SPEED_EN:     spd_en_r  <= cfg_wdata[0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            now_r   <= in_ch.now;
            temp_r  <= (sel_rate != normal_r);
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (per_done) begin
            period_r <= per_q;
            kq_r     <= kq_q[KQ_W-1:0];
            state_r  <= ST_MUL;
          end
        end
        ST_MUL: begin
          lead_r <= lead_nxt;
          if (mul_done) begin
            target_r <= mul_p;
            state_r  <= ST_ADJ;
          end
        end
        ST_ADJ: begin
          target_r <= target_adj;
          state_r  <= ST_CMP;
        end
        ST_CMP: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_temp_r  <= temp_r;
            if (keep) begin
              out_deadline_r <= target_r[TIME_W-1:0];
              out_resynced_r <= 1'b0;
              frame_count_r  <= count_inc;
            end else begin
              out_deadline_r <= now_r;
              out_resynced_r <= 1'b1;
              last_period_r  <= period_r;
              sched_start_r  <= ACC_W'(now_r);
              frame_count_r  <= '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.deadline       = out_deadline_r;
  assign out_ch.resynced       = out_resynced_r;
  assign out_ch.temporary_rate = out_temp_r;

  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> state_r == ST_DIV)
    else $error("tick transfer did not start the dividers");

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    per_done |-> kq_done && state_r == ST_DIV)
    else $error("dividers finished out of step or outside the divide phase");

  a_mul_phase: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> state_r == ST_MUL)
    else $error("multiply finished outside the multiply phase");

  a_resync_clears: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_resynced_r |-> frame_count_r == '0 &&
      sched_start_r == ACC_W'(out_deadline_r))
    else $error("resync result without a restarted schedule");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> state_r == ST_IDLE)
    else $error("result loaded while a tick is still in progress");

endmodule

/* hw/rtl/fdp_sdiv.sv */
// ----------------------------------------------------------------------------
// Frame deadline pacer serial divider
// Restoring division of a 32-bit dividend by a nonzero 10-bit divisor, one
// quotient bit per cycle.
// ----------------------------------------------------------------------------
module fdp_sdiv (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  fdp_pkg::freq_t dividend,
  input  fdp_pkg::rate_t divisor,
  output fdp_pkg::freq_t quotient,
  output logic          done
);
  import fdp_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [DSTEP_W-1:0] cnt_r;
  rate_t              rem_r;
  rate_t              dvs_r;
  freq_t              q_r;

  logic [RATE_W:0] trial;
  logic [RATE_W:0] diff;
  logic            ge;
  rate_t           rem_nxt;

  // The partial remainder stays below the divisor, so it fits in RATE_W bits.
  always_comb begin
    trial   = {rem_r, q_r[FREQ_W-1]};
    diff    = trial - {1'b0, dvs_r};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        dvs_r  <= divisor;
        q_r    <= dividend;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        q_r   <= {q_r[FREQ_W-2:0], ge};
        cnt_r <= cnt_r + DSTEP_W'(1);
        if (cnt_r == DSTEP_W'(FREQ_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = q_r;
  assign done     = done_r;

endmodule

/* hw/rtl/fdp_smul.sv */
// ----------------------------------------------------------------------------
// Frame deadline pacer serial multiply-accumulate
// Computes addend + mcand * mplier modulo 2^64, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module fdp_smul (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  fdp_pkg::acc_t    addend,
  input  fdp_pkg::freq_t   mcand,
  input  fdp_pkg::fcount_t mplier,
  output fdp_pkg::acc_t    product,
  output logic             done
);
  import fdp_pkg::*;

  logic               busy_r;
  logic               done_r;
  logic [MSTEP_W-1:0] cnt_r;
  acc_t               acc_r;
  acc_t               mc_r;
  fcount_t            mp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        acc_r  <= addend;
        mc_r   <= ACC_W'(mcand);
        mp_r   <= mplier;
      end else if (busy_r) begin
        if (mp_r[0]) begin
          acc_r <= acc_r + mc_r;
        end
        mc_r  <= {mc_r[ACC_W-2:0], 1'b0};
        mp_r  <= {1'b0, mp_r[FC_W-1:1]};
        cnt_r <= cnt_r + MSTEP_W'(1);
        if (cnt_r == MSTEP_W'(FC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign product = acc_r;
  assign done    = done_r;

endmodule

/* tb/fdp_deadline_checker.sv */
// ----------------------------------------------------------------------------
// Frame deadline pacer checker
// Watches the tick, result and register-write ports of the pacer, works out
// the deadline that each accepted tick must produce, and compares the results
// against those deadlines in order.
// ----------------------------------------------------------------------------
module fdp_deadline_checker (
  input  logic              clk,
  input  logic              rst_n,
  fdp_in_if                 in_mon,
  fdp_out_if                out_mon,
  input  logic              cfg_we,
  input  fdp_pkg::reg_idx_t cfg_idx,
  input  fdp_pkg::freq_t    cfg_wdata,
  output int unsigned       fail_count,
  output int unsigned       pending
);
  import fdp_pkg::*;

  typedef struct packed {
    time_t deadline;
    logic  resynced;
    logic  temporary_rate;
  } deadline_t;

  // Register copies.
  freq_t             freq_r;
  rate_t             normal_r;
  rate_t             fast_r;
  rate_t             slow_r;
  logic [LEAD_W-1:0] lead_ms_r;
  logic              speed_en_r;

  // Schedule copies.
  acc_t    sched_start;
  fcount_t frame_count;
  acc_t    last_period;

  deadline_t deadline_q[$];
  deadline_t got;
  deadline_t want;

  function automatic deadline_t next_deadline(time_t now, mode_t mode);
    rate_t     rate;
    acc_t      period;
    acc_t      lead;
    acc_t      lead_cap;
    acc_t      target;
    deadline_t d;
    rate = normal_r;
    if (speed_en_r) begin
      if (mode == MODE_FAST) rate = fast_r;
      else if (mode == MODE_SLOW) rate = slow_r;
    end
    d.temporary_rate = (rate != normal_r);
    period   = acc_t'(freq_r) / ((rate == '0) ? acc_t'(1) : acc_t'(rate));
    lead_cap = (acc_t'(freq_r) / acc_t'(MS_PER_S)) * acc_t'(lead_ms_r);
    lead     = (lead_cap < (period >> 1)) ? lead_cap : (period >> 1);
    frame_count = frame_count + 1'b1;
    target = sched_start + acc_t'(frame_count) * period;
    // Early release applies only while the normal rate is in use.
    if (!d.temporary_rate) target = target - lead;
    if ((target + period) >= acc_t'(now) && last_period == period) begin
      d.deadline = target[TIME_W-1:0];
      d.resynced = 1'b0;
    end else begin
      last_period = period;
      sched_start = acc_t'(now);
      frame_count = '0;
      d.deadline  = now;
      d.resynced  = 1'b1;
    end
    return d;
  endfunction

  task automatic apply_write(reg_idx_t idx, freq_t data);
    case (idx)
      REG_COUNTER_FREQ: freq_r = data;
      REG_NORMAL_RATE: begin
        // A zero normal rate is rejected and the old value stays.
        if (data[RATE_W-1:0] != '0) normal_r = data[RATE_W-1:0];
      end
      REG_FAST_RATE: fast_r = data[RATE_W-1:0];
      REG_SLOW_RATE: slow_r = data[RATE_W-1:0];
      REG_LEAD_MS: lead_ms_r = data[LEAD_W-1:0];
      REG_SPEED_EN: speed_en_r = data[0];
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, logic [63:0] got_v, logic [63:0] want_v);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got_v, want_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      freq_r      = RST_COUNTER_FREQ;
      normal_r    = RST_NORMAL_RATE;
      fast_r      = RST_FAST_RATE;
      slow_r      = RST_SLOW_RATE;
      lead_ms_r   = RST_LEAD_MS;
      speed_en_r  = 1'b0;
      sched_start = '0;
      frame_count = '0;
      last_period = '0;
      fail_count  = 0;
      deadline_q.delete();
    end else begin
      if (cfg_we) apply_write(cfg_idx, cfg_wdata);
      // Compare before queuing, so a result never matches a tick of the same edge.
      if (out_mon.valid && out_mon.ready) begin
        got.deadline       = out_mon.deadline;
        got.resynced       = out_mon.resynced;
        got.temporary_rate = out_mon.temporary_rate;
        if (deadline_q.size() == 0) begin
          report_mismatch("unrequested result", 64'(got), '0);
        end else begin
          want = deadline_q.pop_front();
          if (got.deadline !== want.deadline)
            report_mismatch("deadline", 64'(got.deadline), 64'(want.deadline));
          if (got.resynced !== want.resynced)
            report_mismatch("resynced", 64'(got.resynced), 64'(want.resynced));
          if (got.temporary_rate !== want.temporary_rate)
            report_mismatch("temporary_rate", 64'(got.temporary_rate),
                            64'(want.temporary_rate));
        end
      end
      if (in_mon.valid && in_mon.ready)
        deadline_q.push_back(next_deadline(in_mon.now, in_mon.rate_mode));
    end
    pending <= deadline_q.size();
  end

endmodule

/* tb/testbench.sv */
// ----------------------------------------------------------------------------
// Frame deadline pacer testbench
// Drives frame ticks through the pacer under several register settings: a
// short directed run over the corner cases, then random ticks that mostly
// follow the schedule with jumps, rewinds and wild times mixed in. Both
// channels idle in random bursts; a checker beside the block judges results.
// ----------------------------------------------------------------------------
module testbench;
  import fdp_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 1_000_000;
  localparam int          DRAIN_CYCLES    = 80;
  localparam int unsigned HOLD_CYCLES     = 600;
  localparam int          RANDOM_PHASES   = 9;
  localparam int          TICKS_PER_PHASE = 195;
  localparam int          HOLD_PHASE      = 2;
  localparam mode_t       MODE_SPARE      = 2'd3;
  localparam reg_idx_t    REG_SPARE_LO    = 3'd6;
  localparam reg_idx_t    REG_SPARE_HI    = 3'd7;
  localparam time_t       TIME_MAX        = '1;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  reg_idx_t cfg_idx;
  freq_t    cfg_wdata;

  fdp_in_if  in_ch ();
  fdp_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;
  logic        idle_on;
  int unsigned hold_seq = 0;

  // Shadow of the register settings, used only to shape tick times.
  freq_t sh_freq;
  rate_t sh_normal;
  rate_t sh_fast;
  rate_t sh_slow;
  logic  sh_speed_en;
  time_t t_now;
  mode_t cur_mode;

  always #6 clk = ~clk;

  frame_deadline_pacer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  fdp_deadline_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_idx    (cfg_idx),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Result side: random stall bursts, plus one long hold-off on request.
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen = hold_seq;
      hold_left = HOLD_CYCLES - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 12);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic time_t nominal_period(mode_t m);
    rate_t r;
    r = sh_normal;
    if (sh_speed_en && m == MODE_FAST) r = sh_fast;
    else if (sh_speed_en && m == MODE_SLOW) r = sh_slow;
    if (r == '0) r = rate_t'(1);
    return time_t'(sh_freq / r);
  endfunction

  function automatic rate_t random_rate();
    if ($urandom_range(0, 4) == 0) return rate_t'($urandom_range(0, 1023));
    return rate_t'($urandom_range(1, 1000));
  endfunction

  task automatic write_reg(reg_idx_t idx, freq_t data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_COUNTER_FREQ: sh_freq = data;
      REG_NORMAL_RATE: if (data[RATE_W-1:0] != '0) sh_normal = data[RATE_W-1:0];
      REG_FAST_RATE: sh_fast = data[RATE_W-1:0];
      REG_SLOW_RATE: sh_slow = data[RATE_W-1:0];
      REG_SPEED_EN: sh_speed_en = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_tick(time_t now, mode_t mode);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.now       <= now;
    in_ch.rate_mode <= mode;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops offering ticks and lets every outstanding result come back.
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    time_t p;
    // Reset settings, speed control off: a first-tick restart, ticks on time,
    // ignored fast and spare modes, a fall behind, the top of the time range
    // and a schedule that wraps past it.
    p = nominal_period(MODE_NORMAL);
    send_tick('0, MODE_NORMAL);
    send_tick(p, MODE_NORMAL);
    send_tick(2 * p, MODE_FAST);
    send_tick(3 * p, MODE_SPARE);
    send_tick(9 * p, MODE_NORMAL);
    send_tick(TIME_MAX, MODE_SLOW);
    send_tick('0, MODE_NORMAL);
    send_tick(time_t'(5), MODE_NORMAL);
    wait_idle();

    // Speed control with a lead: every mode switch changes the period.
    write_reg(REG_SPEED_EN, 1);
    write_reg(REG_LEAD_MS, 5);
    t_now = time_t'(1000);
    send_tick(t_now, MODE_NORMAL);
    send_tick(t_now, MODE_FAST);
    t_now = t_now + nominal_period(MODE_FAST);
    send_tick(t_now, MODE_FAST);
    send_tick(t_now, MODE_SLOW);
    t_now = t_now + nominal_period(MODE_SLOW);
    send_tick(t_now, MODE_SLOW);
    send_tick(t_now, MODE_SPARE);
    t_now = t_now + nominal_period(MODE_NORMAL);
    send_tick(t_now, MODE_NORMAL);
    wait_idle();

    // Largest settings; a zero normal rate is rejected, a zero fast rate
    // divides as one.
    write_reg(REG_COUNTER_FREQ, '1);
    write_reg(REG_NORMAL_RATE, 1000);
    write_reg(REG_NORMAL_RATE, 0);
    write_reg(REG_FAST_RATE, 0);
    write_reg(REG_SLOW_RATE, 1023);
    write_reg(REG_LEAD_MS, 1023);
    send_tick(t_now, MODE_NORMAL);
    t_now = t_now + nominal_period(MODE_NORMAL);
    send_tick(t_now, MODE_NORMAL);
    send_tick(t_now, MODE_FAST);
    t_now = t_now + nominal_period(MODE_FAST);
    send_tick(t_now, MODE_FAST);
    send_tick(t_now, MODE_SLOW);
    wait_idle();

    // Zero frequency gives a zero period; writes past the last register do
    // nothing; then the smallest nonzero settings.
    write_reg(REG_COUNTER_FREQ, 0);
    write_reg(REG_LEAD_MS, 0);
    write_reg(REG_SPEED_EN, 0);
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, '1);
    send_tick(t_now, MODE_NORMAL);
    send_tick(t_now, MODE_NORMAL);
    send_tick(t_now + 3, MODE_NORMAL);
    wait_idle();
    write_reg(REG_COUNTER_FREQ, 1);
    write_reg(REG_NORMAL_RATE, 1);
    send_tick(t_now + 3, MODE_NORMAL);
    send_tick(t_now + 4, MODE_NORMAL);
    wait_idle();
  endtask

  task automatic program_random_setup();
    freq_t f;
    case ($urandom_range(0, 9))
      0, 1: f = $urandom_range(1, 5000);
      2, 3, 4, 5: f = $urandom_range(100000, 200000000);
      6, 7: f = $urandom;
      8: f = '1;
      default: f = $urandom_range(0, 1);
    endcase
    write_reg(REG_COUNTER_FREQ, f);
    write_reg(REG_NORMAL_RATE, freq_t'(random_rate()));
    write_reg(REG_FAST_RATE, freq_t'(random_rate()));
    write_reg(REG_SLOW_RATE, freq_t'(random_rate()));
    write_reg(REG_LEAD_MS, ($urandom_range(0, 3) == 0) ? freq_t'($urandom)
                                                       : freq_t'($urandom_range(0, 1023)));
    write_reg(REG_SPEED_EN, freq_t'($urandom_range(0, 3) != 0));
    if ($urandom_range(0, 2) == 0)
      write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
  endtask

  task automatic send_random_tick();
    time_t p;
    int    r;
    mode_t m;
    if ($urandom_range(0, 9) == 0) cur_mode = mode_t'($urandom_range(0, 3));
    p = nominal_period(cur_mode);
    m = cur_mode;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      // Near the next slot, a little early or late.
      t_now = t_now + p - p / 8 + $urandom_range(0, 32'(p / 4)) + $urandom_range(0, 1);
    end else if (r < 82) begin
      t_now = t_now + p * $urandom_range(2, 20) + $urandom_range(0, 1000);
    end else if (r < 88) begin
      t_now = t_now - $urandom_range(0, 32'(p));
    end else if (r < 95) begin
      t_now = time_t'({$urandom, $urandom});
      m = mode_t'($urandom_range(0, 3));
    end else begin
      t_now = TIME_MAX - $urandom_range(0, 1000);
    end
    send_tick(t_now, m);
  endtask

  initial begin
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= REG_COUNTER_FREQ;
    cfg_wdata       <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.now       <= '0;
    in_ch.rate_mode <= MODE_NORMAL;
    idle_on         <= 1'b1;
    sh_freq     = RST_COUNTER_FREQ;
    sh_normal   = RST_NORMAL_RATE;
    sh_fast     = RST_FAST_RATE;
    sh_slow     = RST_SLOW_RATE;
    sh_speed_en = 1'b0;
    t_now       = '0;
    cur_mode    = MODE_NORMAL;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      program_random_setup();
      idle_on <= (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      // One long result-side hold-off while ticks keep coming.
      if (ph == HOLD_PHASE) hold_seq <= hold_seq + 1;
      repeat (TICKS_PER_PHASE) send_random_tick();
      wait_idle();
    end

    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/fdp_pkg.sv
hw/rtl/fdp_if.sv
hw/rtl/fdp_sdiv.sv
hw/rtl/fdp_smul.sv
hw/rtl/frame_deadline_pacer_unit.sv
tb/fdp_deadline_checker.sv
tb/testbench.sv
